// ----- sv/vip_pkg.sv -----
`default_nettype none
package vip_pkg;

    // Plane geometry
    localparam int MAX_DIM   = 256;
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int LEN_W     = COORD_W + 1;
    localparam int IDX_W     = 2 * COORD_W;
    localparam int ACC_DEPTH = MAX_DIM * MAX_DIM;

    // Data widths
    localparam int SIZE_W     = 9;
    localparam int VOXEL_W    = 16;
    localparam int ACC_W      = VOXEL_W + COORD_W;
    localparam int DIV_CNT_W  = $clog2(ACC_W);
    localparam int OUT_DATA_W = ((VOXEL_W + IDX_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Z    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROJ_AXIS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE      = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] MODE_MAX = 2'd0;
    localparam logic [1:0] MODE_AVG = 2'd1;
    localparam logic [1:0] MODE_MIN = 2'd2;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One classified voxel, ready for the accumulator update.
    typedef struct packed {
        logic [VOXEL_W-1:0] voxel;
        logic [IDX_W-1:0]   idx;
        logic               first;
        logic               last;
        logic               done;
        logic [1:0]         mode;
        logic [LEN_W-1:0]   len;
    } vip_op_t;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } vip_qstat_t;

    // Sizes of zero act as one, sizes beyond the plane store saturate.
    function automatic logic [LEN_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        int sv;
        sv = int'(s);
        if (sv == 0) begin
            return LEN_W'(1);
        end
        if (sv > MAX_DIM) begin
            return LEN_W'(MAX_DIM);
        end
        return LEN_W'(sv);
    endfunction

endpackage
`default_nettype wire

// ----- sv/vip_front.sv -----
`default_nettype none
module vip_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vip_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [vip_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [vip_pkg::VOXEL_W-1:0]    s_tdata,
    input  wire logic                           q_full,
    output logic                                push,
    output vip_pkg::vip_op_t                    push_op
);
    import vip_pkg::*;

    logic [SIZE_W-1:0]  size_x_reg;
    logic [SIZE_W-1:0]  size_y_reg;
    logic [SIZE_W-1:0]  size_z_reg;
    logic [1:0]         axis_reg;
    logic [1:0]         mode_reg;
    logic [COORD_W-1:0] pos_x_reg, pos_x_next;
    logic [COORD_W-1:0] pos_y_reg, pos_y_next;
    logic [COORD_W-1:0] pos_z_reg, pos_z_next;

    logic [LEN_W-1:0]   sx, sy, sz;
    logic               x_end, y_end, z_end;
    logic               cfg_hit;
    logic [COORD_W-1:0] row, col, along;
    logic [LEN_W-1:0]   len;
    logic [1:0]         mode_eff;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && !q_full;

    assign sx = eff_size(size_x_reg);
    assign sy = eff_size(size_y_reg);
    assign sz = eff_size(size_z_reg);

    assign x_end = (LEN_W'(pos_x_reg) == sx - LEN_W'(1));
    assign y_end = (LEN_W'(pos_y_reg) == sy - LEN_W'(1));
    assign z_end = (LEN_W'(pos_z_reg) == sz - LEN_W'(1));

    // Writes beyond the register list are taken but change nothing.
    assign cfg_hit = cfg_valid && (cfg_addr <= CFG_MODE);

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                row   = pos_y_reg;
                col   = pos_z_reg;
                along = pos_x_reg;
                len   = sx;
            end
            AXIS_Y:
            begin
                row   = pos_z_reg;
                col   = pos_x_reg;
                along = pos_y_reg;
                len   = sy;
            end
            default:
            begin
                row   = pos_x_reg;
                col   = pos_y_reg;
                along = pos_z_reg;
                len   = sz;
            end
        endcase
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_AVG: mode_eff = MODE_AVG;
            MODE_MIN: mode_eff = MODE_MIN;
            default:  mode_eff = MODE_MAX;
        endcase
    end

    always_comb
    begin
        push_op.voxel = s_tdata;
        push_op.idx   = {row, col};
        push_op.first = (along == '0);
        push_op.last  = (LEN_W'(along) == len - LEN_W'(1));
        push_op.done  = x_end && y_end && z_end;
        push_op.mode  = mode_eff;
        push_op.len   = len;
    end

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (cfg_hit)
        begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
        end
        else if (push)
        begin
            if (x_end)
            begin
                pos_x_next = '0;
                if (y_end)
                begin
                    pos_y_next = '0;
                    pos_z_next = z_end ? '0 : pos_z_reg + COORD_W'(1);
                end
                else
                begin
                    pos_y_next = pos_y_reg + COORD_W'(1);
                end
            end
            else
            begin
                pos_x_next = pos_x_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_W'(256);
            size_y_reg <= SIZE_W'(256);
            size_z_reg <= SIZE_W'(256);
            axis_reg   <= AXIS_Z;
            mode_reg   <= MODE_MAX;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            if (cfg_valid)
            begin
                unique case (cfg_addr)
                    CFG_SIZE_X:    size_x_reg <= cfg_data;
                    CFG_SIZE_Y:    size_y_reg <= cfg_data;
                    CFG_SIZE_Z:    size_z_reg <= cfg_data;
                    CFG_PROJ_AXIS: axis_reg   <= cfg_data[1:0];
                    CFG_MODE:      mode_reg   <= cfg_data[1:0];
                    default:       ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/vip_fifo.sv -----
`default_nettype none
module vip_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire vip_pkg::vip_op_t  push_op,
    input  wire logic              pop,
    output vip_pkg::vip_op_t       pop_op,
    output vip_pkg::vip_qstat_t    stat
);
    import vip_pkg::*;

    vip_op_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign pop_op     = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + FIFO_CNT_W'(1);
            2'b01:   count_next = count_reg - FIFO_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/vip_back.sv -----
`default_nettype none
module vip_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_empty,
    output logic                                pop,
    input  wire vip_pkg::vip_op_t               q_op,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [vip_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);
    import vip_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [ACC_W-1:0]     acc_mem [ACC_DEPTH];
    logic [ACC_W-1:0]     rdata_reg;

    logic [1:0]           state_reg, state_next;
    vip_op_t              op_reg, op_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [ACC_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VOXEL_W-1:0]   pix_reg, pix_next;

    logic [ACC_W-1:0]     vox_ext;
    logic [ACC_W-1:0]     acc_new;
    logic [LEN_W:0]       rem_sh;
    logic [LEN_W:0]       rem_diff;
    logic                 rem_ge;
    logic                 mem_we;

    assign vox_ext = ACC_W'(op_reg.voxel);

    // The first voxel of a ray loads the accumulator; the stale read is ignored.
    always_comb
    begin
        if (op_reg.first)
        begin
            acc_new = vox_ext;
        end
        else
        begin
            unique case (op_reg.mode)
                MODE_AVG: acc_new = rdata_reg + vox_ext;
                MODE_MIN: acc_new = (vox_ext < rdata_reg) ? vox_ext : rdata_reg;
                default:  acc_new = (vox_ext > rdata_reg) ? vox_ext : rdata_reg;
            endcase
        end
    end

    // One restoring division step per cycle, quotient bits shift in from the right.
    assign rem_sh   = {rem_reg, quo_reg[ACC_W-1]};
    assign rem_diff = rem_sh - (LEN_W + 1)'(op_reg.len);
    assign rem_ge   = (rem_sh >= (LEN_W + 1)'(op_reg.len));

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        pix_next   = pix_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    op_next    = q_op;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                mem_we = 1'b1;
                if (!op_reg.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (op_reg.mode == MODE_AVG)
                begin
                    quo_next   = acc_new;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    pix_next   = acc_new[VOXEL_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], rem_ge};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(ACC_W - 1))
                begin
                    pix_next   = quo_next[VOXEL_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            acc_mem[op_reg.idx] <= acc_new;
        end
        if (pop)
        begin
            rdata_reg <= acc_mem[q_op.idx];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        pix_reg <= pix_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = op_reg.done;
    assign m_tdata  = OUT_DATA_W'({op_reg.idx[COORD_W-1:0],
                                   op_reg.idx[IDX_W-1:COORD_W],
                                   pix_reg});

endmodule
`default_nettype wire

// ----- sv/volume_intensity_projection.sv -----
`default_nettype none
// Maximum, average or minimum intensity projection of a raster-ordered volume
// (x fastest, then y, then z) along the configured axis. Each input beat is
// one 16-bit voxel; an output beat leaves when a ray is complete and carries
// the projected pixel with its plane coordinates (y,z), (z,x) or (x,y) for
// axis X, Y or Z, with tlast on the last pixel of the projection. The front
// takes a beat per cycle into a two-entry queue while the queue is not full;
// the back does a read-modify-write of the single-port plane store for each
// voxel. A completed ray then hands its pixel to the output, in average mode
// after a bit-serial restoring divide by the ray length. The plane store
// needs no clearing pass: the first voxel of a ray overwrites its entry.
// A configuration write to a defined register restarts the volume at the
// origin and must only happen while the block is idle.
module volume_intensity_projection (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vip_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [vip_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [vip_pkg::VOXEL_W-1:0]    s_tdata,   // [15:0] voxel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [vip_pkg::OUT_DATA_W-1:0]      m_tdata,   // [15:0] pixel, [23:16] row, [31:24] col
    output logic                                m_tlast    // image_done
);
    import vip_pkg::*;

    logic       push;
    logic       pop;
    vip_op_t    push_op;
    vip_op_t    pop_op;
    vip_qstat_t q_stat;

    vip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_stat.full),
        .push      (push),
        .push_op   (push_op)
    );

    vip_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .stat    (q_stat)
    );

    vip_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_stat.empty),
        .pop      (pop),
        .q_op     (pop_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // An accepted voxel is in the queue on the next cycle.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !q_stat.empty)
        else $error("accepted voxel missing from queue");

    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    // A taken pixel is not offered again: the back returns to idle before its next pixel.
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("output beat repeated");

    // Nothing leaves the queue while a pixel waits at the output.
    a_no_pop_on_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !pop)
        else $error("queue popped while output busy");

endmodule
`default_nettype wire
